[rtl/text_glyph_renderer_assert.svh]
// Assertion macros used by the text glyph renderer RTL.
`ifndef TEXT_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_GLYPH_RENDERER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tgr_pkg.sv]
// Package with the types and constants of the text glyph renderer.
package tgr_pkg;

    // Operation codes carried by an input beat.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DRAW   = 2'd1,
        OP_CURSOR = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_PIXELS_PER_LINE = 3'd0,
        CFG_SCREEN_WIDTH    = 3'd1,
        CFG_GLYPH_STRIDE    = 3'd2,
        CFG_TEXT_COLOR      = 3'd3
    } t_cfg_index;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN
    } t_state;

    localparam int COORD_W    = 12;
    localparam int ADDR_W     = 25;
    localparam int PPL_W      = 14;
    localparam int SW_W       = 13;
    localparam int STRIDE_W   = 5;
    localparam int COLOR_W    = 32;
    localparam int CODE_W     = 8;
    localparam int BASE_W     = CODE_W + STRIDE_W;

    localparam logic [COORD_W:0]   GLYPH_WIDTH = 13'd8;
    localparam logic [COORD_W:0]   LINE_STEP   = 13'd18;
    localparam logic [COORD_W:0]   COORD_MAX   = 13'd4095;

    localparam logic [PPL_W-1:0]    PPL_RESET    = 14'd640;
    localparam logic [SW_W-1:0]     SW_RESET     = 13'd640;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 5'd16;
    localparam logic [COLOR_W-1:0]  COLOR_RESET  = 32'hFF00FFFF;

endpackage

[rtl/text_glyph_renderer.sv]
// Top level of the text glyph renderer: command decode, row sequencer and cursor.
//
//  Channel   Handshake             Beat contents
//  -------   --------------------  ---------------------------------------------
//  command   start & !busy         operation, char_code, font_index, font_byte,
//                                  cursor_x_value, cursor_y_value
//  row       o_row_valid (1 cycle) pixel_address, row_mask, pixel_color, last_row
//  config    i_cfg_we              i_cfg_index, i_cfg_data
//
// A load or set-cursor beat does not raise busy; the next beat can follow at once.
// A draw holds busy after it is taken: the PREP state folds the glyph base
// and forms the start address, then the RUN state does one store read per row.
// The rows leave one per cycle, in the cycle after their reads from the store port.
// Reset is synchronous and active low; it clears the cursor, the configuration
// and the sequencer, while the glyph store holds its contents. The row receiver
// cannot stall, so each row beat is shown for exactly one cycle.
module text_glyph_renderer
    import tgr_pkg::*;
#(
    parameter int FONT_BYTES = 4096,
    parameter int GLYPH_ROWS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_operation,
    input  logic [CODE_W-1:0]   i_char_code,
    input  logic [11:0]         i_font_index,
    input  logic [7:0]          i_font_byte,
    input  logic [COORD_W-1:0]  i_cursor_x_value,
    input  logic [COORD_W-1:0]  i_cursor_y_value,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [COLOR_W-1:0]  i_cfg_data,
    output logic                o_row_valid,
    output logic [ADDR_W-1:0]   o_pixel_address,
    output logic [7:0]          o_row_mask,
    output logic [COLOR_W-1:0]  o_pixel_color,
    output logic                o_last_row
);

    localparam int AW = $clog2(FONT_BYTES);
    localparam int RW = $clog2(GLYPH_ROWS);

    // Folds a glyph base into the store by conditional subtraction of
    // shifted store sizes; the base is small enough that six steps suffice.
    function automatic logic [AW-1:0] fold_base(input logic [BASE_W-1:0] base);
        logic [21:0] v;
        logic [21:0] lim;
        v = 22'(base);
        for (int s = 5; s >= 0; s--) begin
            lim = 22'(FONT_BYTES) << s;
            if (v >= lim) begin
                v = v - lim;
            end
        end
        return AW'(v);
    endfunction

    t_state r_state, n_state;

    logic [PPL_W-1:0]    r_ppl;
    logic [SW_W-1:0]     r_sw;
    logic [STRIDE_W-1:0] r_stride;
    logic [COLOR_W-1:0]  r_color;

    logic [COORD_W-1:0]  r_x, r_y;
    logic [BASE_W-1:0]   r_base;
    logic [ADDR_W-1:0]   r_prod;
    logic [ADDR_W-1:0]   r_addr;
    logic [AW-1:0]       r_pos;
    logic [RW-1:0]       r_row;

    logic                r_out_valid;
    logic                r_out_last;
    logic [ADDR_W-1:0]   r_out_addr;

    logic                w_accept;
    logic                w_draw;
    logic                w_load;
    logic                w_run;
    logic                w_final_row;
    logic [16:0]         w_idx_ext;
    logic [AW-1:0]       w_next_pos;
    logic [COORD_W:0]    w_nx;
    logic [COORD_W:0]    w_ny;
    logic                w_wrap;

    assign w_accept    = start && !busy;
    assign w_draw      = w_accept && (t_op'(i_operation) == OP_DRAW);
    assign w_load      = w_accept && (t_op'(i_operation) == OP_LOAD)
                         && (32'(i_font_index) < 32'(FONT_BYTES));
    assign w_final_row = (r_row == RW'(GLYPH_ROWS - 1));
    assign w_idx_ext   = 17'(i_font_index);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppl    <= PPL_RESET;
            r_sw     <= SW_RESET;
            r_stride <= STRIDE_RESET;
            r_color  <= COLOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PIXELS_PER_LINE: r_ppl    <= i_cfg_data[PPL_W-1:0];
                CFG_SCREEN_WIDTH:    r_sw     <= i_cfg_data[SW_W-1:0];
                CFG_GLYPH_STRIDE:    r_stride <= i_cfg_data[STRIDE_W-1:0];
                CFG_TEXT_COLOR:      r_color  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_draw) n_state = S_PREP;
            S_PREP: n_state = S_RUN;
            S_RUN:  if (w_final_row) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        busy  = 1'b0;
        w_run = 1'b0;
        unique case (r_state)
            S_IDLE: ;
            S_PREP: busy = 1'b1;
            S_RUN: begin
                busy  = 1'b1;
                w_run = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Store position of the next row, wrapping at the end of the store.
    assign w_next_pos = ((17'(r_pos) + 17'd1) == 17'(FONT_BYTES)) ? '0 : AW'(r_pos + 1'b1);

    // Draw datapath: base and start address products, then one row a cycle.
    always_ff @(posedge i_clk) begin
        if (w_draw) begin
            r_base <= BASE_W'(i_char_code * r_stride);
            r_prod <= ADDR_W'(r_y * r_ppl);
        end
        if (r_state == S_PREP) begin
            r_pos  <= fold_base(r_base);
            r_addr <= ADDR_W'(r_x) + r_prod;
        end else if (w_run) begin
            r_pos  <= w_next_pos;
            r_addr <= r_addr + ADDR_W'(r_ppl);
        end
        if (w_run) begin
            r_out_addr <= r_addr;
        end
    end

    // Row counter and output beat flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_out_valid <= w_run;
            r_out_last  <= w_run && w_final_row;
            if (w_run) begin
                r_row <= w_final_row ? '0 : RW'(r_row + 1'b1);
            end
        end
    end

    // Cursor advance with line wrap and vertical saturation.
    assign w_nx   = {1'b0, r_x} + GLYPH_WIDTH;
    assign w_wrap = (w_nx > COORD_MAX) || ((w_nx + GLYPH_WIDTH) > r_sw);
    assign w_ny   = {1'b0, r_y} + LINE_STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (w_accept && (t_op'(i_operation) == OP_CURSOR)) begin
            r_x <= i_cursor_x_value;
            r_y <= i_cursor_y_value;
        end else if (w_run && w_final_row) begin
            if (w_wrap) begin
                r_x <= '0;
                r_y <= (w_ny > COORD_MAX) ? COORD_MAX[COORD_W-1:0] : w_ny[COORD_W-1:0];
            end else begin
                r_x <= w_nx[COORD_W-1:0];
            end
        end
    end

    // Glyph store.
    tgr_glyph_ram #(
        .DEPTH (FONT_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_idx_ext[AW-1:0]),
        .i_wdata (i_font_byte),
        .i_re    (w_run),
        .i_raddr (r_pos),
        .o_rdata (o_row_mask)
    );

    assign o_row_valid     = r_out_valid;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_color   = r_color;
    assign o_last_row      = r_out_last;

    // Checks on the sequencer.
    `include "text_glyph_renderer_assert.svh"

    `TGR_ASSERT_NEXT(a_draw_enters_prep, w_draw, r_state == S_PREP, "draw did not start")
    `TGR_ASSERT_SAME(a_row_after_run, o_row_valid, $past(r_state) == S_RUN, "row beat outside a draw")
    `TGR_ASSERT_SAME(a_last_ends_draw, o_last_row, o_row_valid && r_state == S_IDLE, "last row misplaced")
    `TGR_ASSERT_SAME(a_prep_row_zero, r_state == S_PREP, r_row == '0, "row counter not cleared")

endmodule

[rtl/tgr_glyph_ram.sv]
// Glyph byte store: one write port, one registered read port.
module tgr_glyph_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
